[rtl/core/lru_ct_pkg.sv]
`timescale 1ns / 1ps

package lru_ct_pkg;

    // Table geometry.
    localparam int ENTRIES    = 16;
    localparam int KEY_BITS   = 64;
    localparam int VALUE_BITS = 32;

    // Width of the capacity register as seen on the configuration port.
    localparam int CAP_BITS = 5;

    // Reset value of the capacity register.
    localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);

    // Recency rank of one entry and the live entry count.
    localparam int AGE_W = $clog2(ENTRIES);
    localparam int OCC_W = $clog2(ENTRIES + 1);

    // Common width for comparing the occupancy against the capacity.
    localparam int CMP_W = (OCC_W > CAP_BITS) ? OCC_W : CAP_BITS;

    // Request codes.
    typedef enum logic {
        REQ_GET = 1'b0,
        REQ_PUT = 1'b1
    } req_type_t;

    // Controls that go to one entry only.
    typedef struct packed {
        logic touch_sel;  // this entry becomes most recent
        logic load_key;   // take the request key
        logic load_value; // take the request value
        logic set_valid;  // entry becomes live
    } entry_ctl_t;

    // Controls and data shared by all entries.
    typedef struct packed {
        logic                  touch_en; // a recency update happens this cycle
        logic [OCC_W-1:0]      ref_age;  // former rank of the touched entry
        logic [KEY_BITS-1:0]   key;      // request key, for compare and load
        logic [VALUE_BITS-1:0] value;    // request value, for load
    } entry_bcast_t;

    // Status of one entry.
    typedef struct packed {
        logic             valid;
        logic             match;
        logic [AGE_W-1:0] age;
    } entry_stat_t;

endpackage

[rtl/core/lru_ct_entry.sv]
`timescale 1ns / 1ps

module lru_ct_entry (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  lru_ct_pkg::entry_ctl_t             ctl,
    input  lru_ct_pkg::entry_bcast_t           bcast,
    output lru_ct_pkg::entry_stat_t            stat,
    output logic [lru_ct_pkg::KEY_BITS-1:0]    entry_key,
    output logic [lru_ct_pkg::VALUE_BITS-1:0]  entry_value
);

    logic                               valid_reg;
    logic [lru_ct_pkg::AGE_W-1:0]       age_reg;
    logic [lru_ct_pkg::KEY_BITS-1:0]    key_reg;
    logic [lru_ct_pkg::VALUE_BITS-1:0]  value_reg;
    logic                               ages_out;

    // An entry more recent than the touched one moves back by one rank.
    assign ages_out = valid_reg && !ctl.touch_sel &&
                      (lru_ct_pkg::OCC_W'(age_reg) < bcast.ref_age);

    // Valid bit and recency rank.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            age_reg   <= '0;
        end else begin
            if (ctl.set_valid) begin
                valid_reg <= 1'b1;
            end
            if (bcast.touch_en) begin
                if (ctl.touch_sel) begin
                    age_reg <= '0;
                end else if (ages_out) begin
                    age_reg <= lru_ct_pkg::AGE_W'(age_reg + 1'b1);
                end
            end
        end
    end

    // Stored key and value need no reset.
    always_ff @(posedge aclk) begin
        if (ctl.load_key) begin
            key_reg <= bcast.key;
        end
        if (ctl.load_value) begin
            value_reg <= bcast.value;
        end
    end

    assign stat.valid  = valid_reg;
    assign stat.match  = valid_reg && (key_reg == bcast.key);
    assign stat.age    = age_reg;
    assign entry_key   = key_reg;
    assign entry_value = value_reg;

endmodule

[rtl/core/lru_cache_table.sv]
// Fully associative key/value table with least-recently-used replacement.
// Requests enter on the s_ channel (s_valid/s_ready): s_req_type selects a
// get or a put of s_key, and a put stores s_write_value. Every request gives
// exactly one result on the m_ channel (m_valid/m_ready): m_hit, m_read_value
// (value on a get hit, else zero), m_evicted and m_evicted_key.
// A request is registered at acceptance; once the result register is free,
// all entries are searched in parallel, the table is updated and the result
// register is loaded to offer the result. One request per cycle is sustained
// while m_ready is high, with the key compare and rank update over all entries.
// When the receiver stalls, the result register holds and the request
// register holds behind it; s_ready drops only when both are occupied.
// cfg_we/cfg_wdata write the capacity register; write it only while the
// block is idle. Values above the table size act as the table size.
// Reset (aresetn low, synchronous) empties the table, clears both pipeline
// registers and sets the capacity to the table size. No clearing pass is
// needed: the table is usable as soon as reset is released.
`timescale 1ns / 1ps

module lru_cache_table (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [lru_ct_pkg::CAP_BITS-1:0] cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_req_type,
    input  logic [63:0]                     s_key,
    input  logic [31:0]                     s_write_value,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_hit,
    output logic [31:0]                     m_read_value,
    output logic                            m_evicted,
    output logic [63:0]                     m_evicted_key
);

    localparam int N = lru_ct_pkg::ENTRIES;

    // Configuration and occupancy.
    logic [lru_ct_pkg::CAP_BITS-1:0] cap_reg;
    logic [lru_ct_pkg::OCC_W-1:0]    occ_reg;
    logic [lru_ct_pkg::OCC_W-1:0]    occ_next;

    // Request register.
    logic                              req_valid_reg;
    lru_ct_pkg::req_type_t             req_type_reg;
    logic [lru_ct_pkg::KEY_BITS-1:0]   req_key_reg;
    logic [lru_ct_pkg::VALUE_BITS-1:0] req_value_reg;

    // Result register.
    logic                              res_valid_reg;
    logic                              res_hit_reg;
    logic [31:0]                       res_rv_reg;
    logic                              res_ev_reg;
    logic [63:0]                       res_evk_reg;

    // Entry array connections.
    lru_ct_pkg::entry_ctl_t            ctl     [N];
    lru_ct_pkg::entry_stat_t           stat    [N];
    lru_ct_pkg::entry_bcast_t          bcast;
    logic [lru_ct_pkg::KEY_BITS-1:0]   ent_key [N];
    logic [lru_ct_pkg::VALUE_BITS-1:0] ent_val [N];

    logic [N-1:0] match_vec;
    logic [N-1:0] lru_vec;
    logic [N-1:0] inv_vec;
    logic [N-1:0] free_vec;
    logic [N-1:0] touch_vec;
    logic [N-1:0] load_key_vec;
    logic [N-1:0] load_val_vec;
    logic [N-1:0] set_valid_vec;

    logic                              fire;
    logic                              hit;
    logic                              is_put;
    logic                              full;
    logic                              do_evict;
    logic                              do_insert;
    logic [lru_ct_pkg::OCC_W-1:0]      occ_m1;
    logic [lru_ct_pkg::CMP_W-1:0]      cap_sat;
    logic [lru_ct_pkg::AGE_W-1:0]      hit_age;
    logic [lru_ct_pkg::VALUE_BITS-1:0] hit_value;
    logic [lru_ct_pkg::KEY_BITS-1:0]   lru_key;
    logic [lru_ct_pkg::VALUE_BITS-1:0] rv;
    logic [lru_ct_pkg::KEY_BITS-1:0]   evk;

    // Handshake: the request register advances when the result register
    // is free or is being emptied in this cycle.
    assign fire    = req_valid_reg && (!res_valid_reg || m_ready);
    assign s_ready = !req_valid_reg || fire;

    // Capacity register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= lru_ct_pkg::CAP_RESET;
        end else if (cfg_we) begin
            cap_reg <= cfg_wdata;
        end
    end

    // Request register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_valid_reg <= 1'b0;
        end else if (s_ready) begin
            req_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_type_reg  <= lru_ct_pkg::req_type_t'(s_req_type);
            req_key_reg   <= lru_ct_pkg::KEY_BITS'(s_key);
            req_value_reg <= lru_ct_pkg::VALUE_BITS'(s_write_value);
        end
    end

    // Entry array.
    for (genvar g = 0; g < N; g++) begin : g_entry
        assign ctl[g].touch_sel  = touch_vec[g];
        assign ctl[g].load_key   = load_key_vec[g];
        assign ctl[g].load_value = load_val_vec[g];
        assign ctl[g].set_valid  = set_valid_vec[g];

        lru_ct_entry u_entry (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctl         (ctl[g]),
            .bcast       (bcast),
            .stat        (stat[g]),
            .entry_key   (ent_key[g]),
            .entry_value (ent_val[g])
        );
    end

    // Per-entry flags: key match, least recent, free.
    assign occ_m1 = lru_ct_pkg::OCC_W'(occ_reg - 1'b1);

    always_comb begin
        for (int i = 0; i < N; i++) begin
            match_vec[i] = stat[i].match;
            inv_vec[i]   = !stat[i].valid;
            lru_vec[i]   = stat[i].valid && (occ_reg != '0) &&
                           (stat[i].age == occ_m1[lru_ct_pkg::AGE_W-1:0]);
        end
    end

    // Lowest free entry as a one-hot vector.
    assign free_vec = inv_vec & (~inv_vec + N'(1));

    // One-hot selection of the matching and least recent entries.
    always_comb begin
        hit_age   = '0;
        hit_value = '0;
        lru_key   = '0;
        for (int i = 0; i < N; i++) begin
            hit_age   |= match_vec[i] ? stat[i].age : '0;
            hit_value |= match_vec[i] ? ent_val[i] : '0;
            lru_key   |= lru_vec[i] ? ent_key[i] : '0;
        end
    end

    // Decision for the request in the request register.
    assign hit     = |match_vec;
    assign is_put  = (req_type_reg == lru_ct_pkg::REQ_PUT);
    assign cap_sat = (lru_ct_pkg::CMP_W'(cap_reg) > lru_ct_pkg::CMP_W'(N)) ?
                     lru_ct_pkg::CMP_W'(N) : lru_ct_pkg::CMP_W'(cap_reg);
    assign full    = (lru_ct_pkg::CMP_W'(occ_reg) >= cap_sat);

    assign do_evict  = fire && !hit && is_put && full;
    assign do_insert = fire && !hit && is_put && !full && (|inv_vec);

    always_comb begin
        touch_vec      = '0;
        load_key_vec   = '0;
        load_val_vec   = '0;
        set_valid_vec  = '0;
        bcast.key      = req_key_reg;
        bcast.value    = req_value_reg;
        bcast.touch_en = 1'b0;
        bcast.ref_age  = '0;
        occ_next       = occ_reg;
        rv             = '0;
        evk            = '0;
        if (fire && hit) begin
            touch_vec      = match_vec;
            load_val_vec   = is_put ? match_vec : '0;
            bcast.touch_en = 1'b1;
            bcast.ref_age  = lru_ct_pkg::OCC_W'(hit_age);
            rv             = is_put ? '0 : hit_value;
        end else if (do_evict) begin
            // With an empty table the new key itself is turned away.
            if (occ_reg == '0) begin
                evk = req_key_reg;
            end else begin
                evk            = lru_key;
                touch_vec      = lru_vec;
                load_key_vec   = lru_vec;
                load_val_vec   = lru_vec;
                bcast.touch_en = 1'b1;
                bcast.ref_age  = occ_m1;
            end
        end else if (do_insert) begin
            touch_vec      = free_vec;
            load_key_vec   = free_vec;
            load_val_vec   = free_vec;
            set_valid_vec  = free_vec;
            bcast.touch_en = 1'b1;
            bcast.ref_age  = occ_reg;
            occ_next       = lru_ct_pkg::OCC_W'(occ_reg + 1'b1);
        end
    end

    // Occupancy counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= '0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else if (fire) begin
            res_valid_reg <= 1'b1;
        end else if (m_ready) begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            res_hit_reg <= hit;
            res_rv_reg  <= 32'(rv);
            res_ev_reg  <= do_evict;
            res_evk_reg <= 64'(evk);
        end
    end

    assign m_valid       = res_valid_reg;
    assign m_hit         = res_hit_reg;
    assign m_read_value  = res_rv_reg;
    assign m_evicted     = res_ev_reg;
    assign m_evicted_key = res_evk_reg;

    // The occupancy always equals the number of live entries.
    a_occ_count: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(~inv_vec) == int'(occ_reg))
        else $error("occupancy does not match live entry count");

    // A key is never held by more than one live entry.
    a_unique_key: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(match_vec))
        else $error("key present in more than one entry");

    // At most one entry holds the least recent rank, and one does when the table is not empty.
    a_unique_lru: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(lru_vec) && ((occ_reg == '0) || (lru_vec != '0)))
        else $error("least recent entry not unique");

    // An insertion grows the occupancy by exactly one.
    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        do_insert |=> (occ_reg == lru_ct_pkg::OCC_W'($past(occ_reg) + 1'b1)))
        else $error("insertion did not grow occupancy");

    // An eviction is only reported for a request that missed.
    a_evict_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_evicted) |-> !m_hit)
        else $error("eviction reported on a hit");

endmodule
